[design/gpcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcs_pkg
// Shared types, constants and helpers of the grid pitch column scanner.
// ----------------------------------------------------------------------------
package gpcs_pkg;

  // match window for a shade compare
  localparam int unsigned COLOR_THRESHOLD = 35;
  // junction limits
  localparam int unsigned MAX_JUNCTIONS   = 7;
  localparam int unsigned MIN_JUNCTIONS   = 4;
  // smallest half spacing
  localparam int unsigned MIN_OFFSET      = 5;
  // board is 8 cells on a side, applied as a shift
  localparam int unsigned BOARD_CELLS     = 8;
  localparam int unsigned BOARD_SHIFT     = $clog2(BOARD_CELLS);

  localparam int unsigned CNT_W     = 3;
  localparam int unsigned GAP_N     = MAX_JUNCTIONS - 1;
  localparam int unsigned GAP_IDX_W = $clog2(GAP_N);

  // input item
  typedef struct packed {
    logic [7:0]  pixel;
    logic [11:0] column;
    logic [11:0] row;
    logic        frame_end;
  } in_item_t;

  // result item
  typedef struct packed {
    logic             found;
    logic [11:0]      board_left;
    logic [11:0]      board_top;
    logic [11:0]      cell_size;
    logic [CNT_W-1:0] junctions_seen;
  } out_item_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FIRST_X  = 3'd0,
    REG_FIRST_Y  = 3'd1,
    REG_SECOND_X = 3'd2,
    REG_SECOND_Y = 3'd3,
    REG_SHADE_A  = 3'd4,
    REG_SHADE_B  = 3'd5,
    REG_IMG_W    = 3'd6,
    REG_IMG_H    = 3'd7
  } cfg_reg_t;

  // controller states
  typedef enum logic [1:0] {
    ST_SCAN,
    ST_RANK,
    ST_PLACE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_pixel;
    logic rank_step;
    logic load_out;
  } gpcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_req;
    logic enough;
    logic rank_hit;
  } gpcs_status_t;

  // true when two gray levels lie within the threshold
  function automatic logic near_shade(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d < 8'(COLOR_THRESHOLD);
  endfunction

endpackage

[design/gpcs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcs_ctrl
// Sequencer: pixel scan, median ranking pass, result placement and handoff.
// ----------------------------------------------------------------------------
module gpcs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  gpcs_pkg::gpcs_status_t status,
  output gpcs_pkg::gpcs_cmd_t    cmd
);

  gpcs_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gpcs_pkg::ST_SCAN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd.take_pixel = 1'b0;
    cmd.rank_step  = 1'b0;
    cmd.load_out   = 1'b0;
    in_ready       = 1'b0;
    case (state_r)
      gpcs_pkg::ST_SCAN: begin
        in_ready       = 1'b1;
        cmd.take_pixel = in_valid;
        if (in_valid && status.emit_req) begin
          state_nxt = status.enough ? gpcs_pkg::ST_RANK : gpcs_pkg::ST_PLACE;
        end
      end
      gpcs_pkg::ST_RANK: begin
        cmd.rank_step = 1'b1;
        if (status.rank_hit) begin
          state_nxt = gpcs_pkg::ST_PLACE;
        end
      end
      gpcs_pkg::ST_PLACE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = gpcs_pkg::ST_SCAN;
        end
      end
      default: begin
        state_nxt = gpcs_pkg::ST_SCAN;
      end
    endcase
  end

  // result valid holds until the transfer
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[design/gpcs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcs_datapath
// Config registers, per-pixel junction detection, gap store, median rank
// unit and board placement with the result register.
// ----------------------------------------------------------------------------
module gpcs_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [12:0]           cfg_data,
  input  gpcs_pkg::in_item_t     in_data,
  input  gpcs_pkg::gpcs_cmd_t    cmd,
  output gpcs_pkg::gpcs_status_t status,
  output gpcs_pkg::out_item_t    out_data
);

  // configuration
  logic [11:0] first_x_r, first_y_r, second_x_r, second_y_r;
  logic [7:0]  shade_a_r, shade_b_r;
  logic [12:0] img_w_r, img_h_r;

  // per-frame scan state
  logic                          look_flip_r;
  logic [7:0]                    left_sample_r;
  logic [12:0]                   next_row_r;
  logic [gpcs_pkg::CNT_W-1:0]    count_r;
  logic                          frame_done_r;
  logic [11:0]                   row0_r;
  logic [11:0]                   last_row_r;
  logic [11:0]                   gaps_r [gpcs_pkg::GAP_N];

  // result computation
  logic [gpcs_pkg::CNT_W-1:0]     em_cnt_r;
  logic [gpcs_pkg::GAP_IDX_W-1:0] idx_r;
  logic [11:0]                    cell_r;
  gpcs_pkg::out_item_t            out_r;

  // geometry from the clicks
  logic [12:0] x_sum;
  logic [11:0] jx;
  logic [11:0] dx;
  logic [9:0]  off;
  logic [12:0] rx;
  logic        cols_ok;
  logic [11:0] lx;
  logic [11:0] min_y;
  logic [12:0] start_row;

  // per-pixel decision
  logic        active;
  logic        at_left, at_right;
  logic        flipped, normal, hit;
  logic [gpcs_pkg::CNT_W-1:0] cnt_after;
  logic        last_hit;

  // rank unit
  logic [11:0]                   cand;
  logic [gpcs_pkg::CNT_W-1:0]    ng;
  logic [gpcs_pkg::CNT_W-1:0]    rank;

  // placement
  logic [14:0]        w;
  logic               fit;
  logic signed [15:0] bx_raw, by_raw, lim_x, lim_y, bx_c, by_c;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r  <= '0;
      first_y_r  <= '0;
      second_x_r <= '0;
      second_y_r <= '0;
      shade_a_r  <= '0;
      shade_b_r  <= '0;
      img_w_r    <= 13'd4096;
      img_h_r    <= 13'd4096;
    end else if (cfg_valid) begin
      case (gpcs_pkg::cfg_reg_t'(cfg_index))
        gpcs_pkg::REG_FIRST_X:  first_x_r  <= cfg_data[11:0];
        gpcs_pkg::REG_FIRST_Y:  first_y_r  <= cfg_data[11:0];
        gpcs_pkg::REG_SECOND_X: second_x_r <= cfg_data[11:0];
        gpcs_pkg::REG_SECOND_Y: second_y_r <= cfg_data[11:0];
        gpcs_pkg::REG_SHADE_A:  shade_a_r  <= cfg_data[7:0];
        gpcs_pkg::REG_SHADE_B:  shade_b_r  <= cfg_data[7:0];
        gpcs_pkg::REG_IMG_W:    img_w_r    <= cfg_data;
        gpcs_pkg::REG_IMG_H:    img_h_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // reference column, half spacing and scan window
  always_comb begin
    x_sum     = {1'b0, first_x_r} + {1'b0, second_x_r};
    jx        = x_sum[12:1];
    dx        = (second_x_r > first_x_r) ? (second_x_r - first_x_r)
                                         : (first_x_r - second_x_r);
    off       = (dx[11:2] < 10'(gpcs_pkg::MIN_OFFSET)) ? 10'(gpcs_pkg::MIN_OFFSET)
                                                      : dx[11:2];
    lx        = jx - {2'b0, off};
    rx        = {1'b0, jx} + {3'b0, off};
    cols_ok   = (jx >= {2'b0, off}) && (rx < img_w_r);
    min_y     = (first_y_r < second_y_r) ? first_y_r : second_y_r;
    start_row = (next_row_r > {1'b0, min_y}) ? next_row_r : {1'b0, min_y};
  end

  // junction test on the right sample
  always_comb begin
    active   = !frame_done_r && cols_ok;
    at_left  = active && (in_data.column == lx);
    at_right = active && !at_left && ({1'b0, in_data.column} == rx)
               && ({1'b0, in_data.row} >= start_row)
               && ({1'b0, in_data.row} < img_h_r);
    flipped  = gpcs_pkg::near_shade(left_sample_r, shade_b_r)
               && gpcs_pkg::near_shade(in_data.pixel, shade_a_r);
    normal   = gpcs_pkg::near_shade(left_sample_r, shade_a_r)
               && gpcs_pkg::near_shade(in_data.pixel, shade_b_r);
    hit      = at_right && (look_flip_r ? flipped : normal);
    cnt_after = hit ? (count_r + 1'b1) : count_r;
    last_hit = hit && (cnt_after == gpcs_pkg::CNT_W'(gpcs_pkg::MAX_JUNCTIONS));
  end

  assign status.emit_req = last_hit || (in_data.frame_end && !frame_done_r);
  assign status.enough   = (cnt_after >= gpcs_pkg::CNT_W'(gpcs_pkg::MIN_JUNCTIONS));

  // scan state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_flip_r   <= 1'b1;
      left_sample_r <= '0;
      next_row_r    <= '0;
      count_r       <= '0;
      frame_done_r  <= 1'b0;
    end else if (cmd.take_pixel) begin
      if (at_left) begin
        left_sample_r <= in_data.pixel;
      end
      if (in_data.frame_end) begin
        look_flip_r  <= 1'b1;
        next_row_r   <= '0;
        count_r      <= '0;
        frame_done_r <= 1'b0;
      end else if (hit) begin
        look_flip_r  <= !look_flip_r;
        next_row_r   <= 13'({1'b0, in_data.row} + {2'b0, off, 1'b0} + 13'd1);
        count_r      <= cnt_after;
        frame_done_r <= last_hit;
      end
    end
  end

  // junction rows kept as first row plus gaps
  always_ff @(posedge clk) begin
    if (cmd.take_pixel && hit) begin
      last_row_r <= in_data.row;
      if (count_r == '0) begin
        row0_r <= in_data.row;
      end else begin
        gaps_r[gpcs_pkg::GAP_IDX_W'(count_r - 1'b1)] <= in_data.row - last_row_r;
      end
    end
  end

  // median by rank: candidate whose rank is half the gap count
  always_comb begin
    ng   = em_cnt_r - 1'b1;
    cand = gaps_r[idx_r];
    rank = '0;
    for (int j = 0; j < gpcs_pkg::GAP_N; j++) begin
      if ((gpcs_pkg::CNT_W'(j) < ng)
          && ((gaps_r[j] < cand)
              || ((gaps_r[j] == cand) && (gpcs_pkg::GAP_IDX_W'(j) < idx_r)))) begin
        rank = rank + 1'b1;
      end
    end
  end

  assign status.rank_hit = (rank == (ng >> 1));

  // snapshot at the emit and ranking sweep
  always_ff @(posedge clk) begin
    if (cmd.take_pixel && status.emit_req) begin
      em_cnt_r <= cnt_after;
      idx_r    <= '0;
    end else if (cmd.rank_step) begin
      idx_r <= idx_r + 1'b1;
      if (status.rank_hit) begin
        cell_r <= cand;
      end
    end
  end

  // board fit and corner clamp
  always_comb begin
    w      = {3'b0, cell_r} << gpcs_pkg::BOARD_SHIFT;
    fit    = (em_cnt_r >= gpcs_pkg::CNT_W'(gpcs_pkg::MIN_JUNCTIONS))
             && (w <= {2'b0, img_w_r}) && (w <= {2'b0, img_h_r});
    bx_raw = $signed({4'b0, jx}) - $signed({4'b0, cell_r});
    by_raw = $signed({4'b0, row0_r}) - $signed({4'b0, cell_r});
    lim_x  = $signed({3'b0, img_w_r}) - $signed({1'b0, w});
    lim_y  = $signed({3'b0, img_h_r}) - $signed({1'b0, w});
    bx_c   = (bx_raw > lim_x) ? lim_x : bx_raw;
    by_c   = (by_raw > lim_y) ? lim_y : by_raw;
    if (bx_c < 0) bx_c = '0;
    if (by_c < 0) by_c = '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.found          <= fit;
      out_r.board_left     <= fit ? bx_c[11:0] : 12'd0;
      out_r.board_top      <= fit ? by_c[11:0] : 12'd0;
      out_r.cell_size      <= fit ? cell_r : 12'd0;
      out_r.junctions_seen <= em_cnt_r;
    end
  end

  assign out_data = out_r;

endmodule

[design/grid_pitch_column_scanner_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_pitch_column_scanner_unit
// Locates an 8x8 checkered board in a grayscale raster from two clicks and
// reports cell size and board corner once per frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in_     | input     | in_valid/in_ready   | in_data  (pixel, column, row,
//          |           |                     |           frame_end)
//  out_    | output    | out_valid/out_ready | out_data (found, corner, cell,
//          |           |                     |           junctions_seen)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One pixel per cycle while scanning. A pixel that ends the search (frame
//  end or seventh junction) is followed by a ranking pass over the stored
//  gaps (skipped below four junctions) and a placement step, during which
//  in_ready is low. A pending result does not stop the scan; placement
//  waits only if the previous result has not been taken. Configuration is
//  accepted every cycle. Synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
module grid_pitch_column_scanner_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gpcs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gpcs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [12:0]         cfg_data
);

  gpcs_pkg::gpcs_cmd_t    cmd;
  gpcs_pkg::gpcs_status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  gpcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  gpcs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  // a located board always has enough junctions
  a_found_enough: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found)
      |-> (out_data.junctions_seen >= 3'(gpcs_pkg::MIN_JUNCTIONS)))
    else $error("found with too few junctions");

  // a failed search reports a zero corner and cell
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found)
      |-> (out_data.board_left == '0 && out_data.board_top == '0
           && out_data.cell_size == '0))
    else $error("failure result carries geometry");

  // junction gaps are at least twice the minimum half spacing plus one
  a_cell_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found)
      |-> (out_data.cell_size >= 12'(2 * gpcs_pkg::MIN_OFFSET + 1)))
    else $error("cell size below scan spacing");

  // no pixel is taken while a result is being computed
  a_stall_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && status.emit_req) |=> !in_ready)
    else $error("input taken during result computation");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid pitch column scanner. Streams short sparse
// frames with planted junction rows and noise, predicts the one board result
// per frame and compares every result transfer field by field, under random
// idling, a long receiver hold-off and a range of register settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 3000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  gpcs_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  gpcs_pkg::out_item_t  out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  gpcs_pkg::cfg_reg_t   cfg_index = gpcs_pkg::REG_FIRST_X;
  logic [12:0]          cfg_data = '0;

  grid_pitch_column_scanner_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  gpcs_pkg::in_item_t  pixel_q[$];
  gpcs_pkg::out_item_t board_q[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;
  logic      hold_req = 1'b0;
  int        fail_cnt = 0;
  int        quiet_cycles = 0;
  int        pushed = 0;

  // register copy
  int click1_x = 0, click1_y = 0, click2_x = 0, click2_y = 0;
  int gray_a = 0, gray_b = 0;
  int img_w = 4096, img_h = 4096;

  // per-frame scan state
  bit seek_flip = 1'b1;
  int left_px = 0;
  int row_floor = 0;
  int jcount = 0;
  int jrows[gpcs_pkg::MAX_JUNCTIONS];
  bit frame_closed = 1'b0;

  function automatic int scan_col();
    return (click1_x + click2_x) / 2;
  endfunction

  function automatic int half_gap();
    int d;
    d = (click2_x > click1_x) ? click2_x - click1_x : click1_x - click2_x;
    d = d / 4;
    return (d < gpcs_pkg::MIN_OFFSET) ? gpcs_pkg::MIN_OFFSET : d;
  endfunction

  function automatic bit within_shade(input int v, input int s);
    int d;
    d = (v > s) ? v - s : s - v;
    return d < gpcs_pkg::COLOR_THRESHOLD;
  endfunction

  // board placement from the recorded junction rows
  function automatic gpcs_pkg::out_item_t board_fix();
    gpcs_pkg::out_item_t r;
    int gap[gpcs_pkg::MAX_JUNCTIONS];
    int ng, pitch, w, bx, by, t, j;
    r = '0;
    r.junctions_seen = 3'(jcount);
    if (jcount < gpcs_pkg::MIN_JUNCTIONS) return r;
    ng = jcount - 1;
    // insertion sort of the gaps, median picked below
    for (int i = 0; i < ng; i++) begin
      t = jrows[i + 1] - jrows[i];
      j = i;
      while (j > 0 && gap[j - 1] > t) begin
        gap[j] = gap[j - 1];
        j--;
      end
      gap[j] = t;
    end
    pitch = gap[ng / 2];
    w = pitch * gpcs_pkg::BOARD_CELLS;
    if (w > img_w || w > img_h) return r;
    bx = scan_col() - pitch;
    by = jrows[0] - pitch;
    if (bx > img_w - w) bx = img_w - w;
    if (bx < 0) bx = 0;
    if (by > img_h - w) by = img_h - w;
    if (by < 0) by = 0;
    r.found      = 1'b1;
    r.board_left = 12'(bx);
    r.board_top  = 12'(by);
    r.cell_size  = 12'(pitch);
    return r;
  endfunction

  // advance the scan by one accepted pixel, queue any board result
  function automatic void track_pixel(input gpcs_pkg::in_item_t it);
    int lx, rx, start, col, row;
    bit flp, nrm;
    col = it.column;
    row = it.row;
    if (!frame_closed) begin
      lx = scan_col() - half_gap();
      rx = scan_col() + half_gap();
      start = (click1_y < click2_y) ? click1_y : click2_y;
      if (row_floor > start) start = row_floor;
      if (lx >= 0 && rx < img_w) begin
        if (col == lx) begin
          left_px = it.pixel;
        end else if (col == rx && row >= start && row < img_h) begin
          flp = within_shade(left_px, gray_b) && within_shade(it.pixel, gray_a);
          nrm = within_shade(left_px, gray_a) && within_shade(it.pixel, gray_b);
          if (seek_flip ? flp : nrm) begin
            if (jcount < gpcs_pkg::MAX_JUNCTIONS) jrows[jcount] = row;
            jcount++;
            seek_flip = !seek_flip;
            row_floor = (row + 2 * half_gap() + 1) & 'h1FFF;
            if (jcount >= gpcs_pkg::MAX_JUNCTIONS) begin
              board_q = {board_q, board_fix()};
              frame_closed = 1'b1;
            end
          end
        end
      end
      if (it.frame_end && !frame_closed) board_q = {board_q, board_fix()};
    end
    if (it.frame_end) begin
      seek_flip = 1'b1;
      row_floor = 0;
      jcount = 0;
      frame_closed = 1'b0;
      foreach (jrows[i]) jrows[i] = 0;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_px(input int pix, input int col, input int row, input bit fe);
    gpcs_pkg::in_item_t it;
    it.pixel     = pix[7:0];
    it.column    = col[11:0];
    it.row       = row[11:0];
    it.frame_end = fe;
    pixel_q = {pixel_q, it};
    pushed++;
  endtask

  function automatic int near_gray(input int s);
    int v;
    v = s + int'($urandom_range(0, 68)) - 34;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // left and right samples of one row, flipped or normal pattern
  task automatic push_junction(input int row, input bit flip_row, input bit exact);
    int ls, rs;
    ls = flip_row ? gray_b : gray_a;
    rs = flip_row ? gray_a : gray_b;
    push_px(exact ? ls : near_gray(ls), scan_col() - half_gap(), row, 1'b0);
    push_px(exact ? rs : near_gray(rs), scan_col() + half_gap(), row, 1'b0);
  endtask

  // one frame: alternating junction rows with noise and broken rows mixed in
  task automatic add_frame();
    int r, spread, n, col;
    bit flip_row;
    n = $urandom_range(0, 8);
    spread = ($urandom_range(0, 3) == 0) ? 300 : 8;
    r = ((click1_y < click2_y) ? click1_y : click2_y) + $urandom_range(0, 20);
    flip_row = 1'b1;
    for (int k = 0; k < n && r < 4096; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0: col = scan_col() - half_gap();
          1: col = scan_col() + half_gap();
          default: col = $urandom_range(0, 4095);
        endcase
        push_px($urandom_range(0, 255), col, $urandom_range(0, 4095),
                $urandom_range(0, 39) == 0);
      end
      // wrong pattern for the row, then the real one just below
      if ($urandom_range(0, 5) == 0) begin
        push_junction(r, !flip_row, 1'b0);
        r++;
      end
      if (r < 4096) push_junction(r, flip_row, 1'b0);
      flip_row = !flip_row;
      r += 2 * half_gap() + 1 + $urandom_range(0, spread);
    end
    push_px($urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b1);
  endtask

  task automatic write_reg(input gpcs_pkg::cfg_reg_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[12:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gpcs_pkg::REG_FIRST_X:  click1_x = val & 'hFFF;
      gpcs_pkg::REG_FIRST_Y:  click1_y = val & 'hFFF;
      gpcs_pkg::REG_SECOND_X: click2_x = val & 'hFFF;
      gpcs_pkg::REG_SECOND_Y: click2_y = val & 'hFFF;
      gpcs_pkg::REG_SHADE_A:  gray_a   = val & 'hFF;
      gpcs_pkg::REG_SHADE_B:  gray_b   = val & 'hFF;
      gpcs_pkg::REG_IMG_W:    img_w    = val & 'h1FFF;
      gpcs_pkg::REG_IMG_H:    img_h    = val & 'h1FFF;
      default: ;
    endcase
  endtask

  task automatic set_config(input int x1, input int y1, input int x2, input int y2,
                            input int sa, input int sb, input int w, input int h);
    write_reg(gpcs_pkg::REG_FIRST_X, x1);
    write_reg(gpcs_pkg::REG_FIRST_Y, y1);
    write_reg(gpcs_pkg::REG_SECOND_X, x2);
    write_reg(gpcs_pkg::REG_SECOND_Y, y2);
    write_reg(gpcs_pkg::REG_SHADE_A, sa);
    write_reg(gpcs_pkg::REG_SHADE_B, sb);
    write_reg(gpcs_pkg::REG_IMG_W, w);
    write_reg(gpcs_pkg::REG_IMG_H, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    int w, h, xa, xb, d, ya;
    w  = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(96, 4096);
    h  = ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(600, 4096);
    xa = $urandom_range(40, w - 41);
    d  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
    xb = $urandom_range(0, 1) ? xa + d : xa - d;
    if (xb < 0) xb = 0;
    if (xb > 4095) xb = 4095;
    ya = $urandom_range(0, 150);
    set_config(xa, ya + $urandom_range(0, 4), xb, ya + $urandom_range(0, 4),
               $urandom_range(0, 255), $urandom_range(0, 255), w, h);
  endtask

  // wait until every pixel is sent and every result taken, then let it go quiet
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid || board_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold,
                           input bit mid_pause, input int min_items, input int min_frames);
    int frames, base;
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    if (long_hold) begin
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
    end
    frames = 0;
    base = pushed;
    while (pushed - base < min_items || frames < min_frames) begin
      add_frame();
      frames++;
      if (mid_pause && frames == 5) settle();
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, a seven-junction frame with pixels after the
    // result, and a four-junction frame whose top edge clamps to zero
    set_config(100, 52, 140, 50, 0, 255, 4096, 4096);
    push_px(0, 0, 0, 1'b0);
    push_px(255, 4095, 4095, 1'b0);
    for (int k = 0; k < 7; k++) push_junction(50 + 21 * k, k % 2 == 0, 1'b1);
    push_px(255, 130, 200, 1'b0);
    push_px(0, 0, 300, 1'b1);
    for (int k = 0; k < 4; k++) push_junction(60 + 70 * k, k % 2 == 0, 1'b1);
    push_px(7, 4095, 4095, 1'b1);
    settle();

    // random frames under each idling mix
    random_config();
    run_phase(0, 0, 1'b0, 1'b0, 130, 10);
    random_config();
    run_phase(47, 0, 1'b1, 1'b0, 130, 10);
    random_config();
    run_phase(0, 47, 1'b0, 1'b1, 130, 10);
    random_config();
    run_phase(24, 24, 1'b0, 1'b0, 130, 10);

    // widest click spacing with extreme shades
    set_config(0, 4095, 4095, 0, 255, 0, 4096, 4096);
    run_phase(24, 24, 1'b0, 1'b0, 20, 3);
    // one-pixel image, columns never inside
    set_config(0, 0, 0, 0, 128, 128, 1, 1);
    run_phase(0, 0, 1'b0, 1'b0, 20, 3);
    // reference column on the right border
    set_config(4095, 0, 4095, 4095, 0, 0, 4096, 4096);
    run_phase(0, 0, 1'b0, 1'b0, 20, 3);

    if (fail_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------------ driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n)
      hold_left <= 0;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
    else if (hold_req)
      hold_left <= HOLD_CYCLES;
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor
    gpcs_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_pixel(in_data);
      if (out_valid && out_ready) begin
        if (board_q.size() == 0) begin
          $error("result transfer with no expectation pending");
          fail_cnt++;
        end else begin
          want = board_q.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            fail_cnt++;
          end
          if (out_data.board_left !== want.board_left) begin
            $error("board_left: expected %0d, got %0d", want.board_left, out_data.board_left);
            fail_cnt++;
          end
          if (out_data.board_top !== want.board_top) begin
            $error("board_top: expected %0d, got %0d", want.board_top, out_data.board_top);
            fail_cnt++;
          end
          if (out_data.cell_size !== want.cell_size) begin
            $error("cell_size: expected %0d, got %0d", want.cell_size, out_data.cell_size);
            fail_cnt++;
          end
          if (out_data.junctions_seen !== want.junctions_seen) begin
            $error("junctions_seen: expected %0d, got %0d",
                   want.junctions_seen, out_data.junctions_seen);
            fail_cnt++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
